>>> design/color_markup_partitioner_macros.svh
// assertion macros shared by the color markup partitioner modules
// no dependencies; bodies are empty when SYNTHESIS is set
`ifndef COLOR_MARKUP_PARTITIONER_MACROS_SVH
`define COLOR_MARKUP_PARTITIONER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define CMP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent that must hold in the cycle after the antecedent
`define CMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CMP_ASSERT(lbl, clk, rstn, prop, msg)
`define CMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/cmp_pkg.sv
// shared types, codes and constants of the color markup partitioner
// no dependencies
package cmp_pkg;

	// character width used for compares; input words wider than this are cut
	localparam int CHAR_BITS      = 16;
	localparam int HEX_DIGITS_DEF = 8;
	localparam int MAX_LENGTH_DEF = 4096;
	localparam int QUEUE_DEPTH    = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_MARKER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_MARKER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TEXT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BACK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP        = 3'd4;

	localparam logic [31:0] DEFAULT_TEXT_RESET = 32'hFFFF_FFFF;
	localparam logic [31:0] DEFAULT_BACK_RESET = 32'h0000_0000;

	typedef logic [CHAR_BITS-1:0] char_t;

	// character codes
	localparam char_t CH_SPACE = CHAR_BITS'(32);
	localparam char_t CH_NL    = CHAR_BITS'(10);
	localparam char_t CH_TAB   = CHAR_BITS'(9);
	localparam char_t CH_0     = CHAR_BITS'(48);
	localparam char_t CH_9     = CHAR_BITS'(57);
	localparam char_t CH_UA    = CHAR_BITS'(65);
	localparam char_t CH_UF    = CHAR_BITS'(70);
	localparam char_t CH_LA    = CHAR_BITS'(97);
	localparam char_t CH_LF    = CHAR_BITS'(102);

	typedef enum logic [1:0] {
		KIND_TEXT    = 2'd0,
		KIND_COLOR   = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_TAB     = 2'd3
	} kind_t;

	typedef enum logic {
		FE_RUN,
		FE_DRAIN
	} front_state_t;

	// one classified head character, or the end-of-string mark
	typedef struct packed {
		kind_t       kind;
		logic        space;
		logic        text_sel;
		logic [31:0] value;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [15:0] text_marker;
		logic [15:0] back_marker;
	} cfg_front_t;

	typedef struct packed {
		logic        strip;
		logic [31:0] def_text;
		logic [31:0] def_back;
		logic        load_text;
		logic        load_back;
		logic [31:0] load_value;
	} cfg_back_t;

endpackage

>>> design/cmp_front.sv
// front end: lookahead window, escape recognition and head classification
// depends on cmp_pkg and color_markup_partitioner_macros.svh
`include "color_markup_partitioner_macros.svh"

module cmp_front #(
	parameter int HEX_DIGITS = cmp_pkg::HEX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // char_code
	input  logic                s_tlast,   // last_char
	input  cmp_pkg::cfg_front_t cfg,
	input  logic                q_full,
	output logic                q_push,
	output cmp_pkg::token_t     q_tok,
	output logic                idle
);

	localparam int ESC_LEN = HEX_DIGITS + 2;
	localparam int FILL_W  = $clog2(ESC_LEN + 1);
	localparam int IDX_W   = $clog2(ESC_LEN);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ESC_LEN);
	localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

	cmp_pkg::char_t          win_q [ESC_LEN];
	cmp_pkg::char_t          win_d [ESC_LEN];
	logic [FILL_W-1:0]       fill_q, fill_d;
	cmp_pkg::front_state_t   state_q, state_d;
	logic                    active_q, active_d;

	logic                    full, is_tm, is_bm, digits_ok, is_color;
	cmp_pkg::kind_t          head_kind;
	logic [31:0]             head_value;
	logic                    proc, end_push, accept;
	logic [FILL_W-1:0]       fill_after;

	// hex digit decode: valid flag and nibble
	function automatic logic [4:0] hex_decode(input cmp_pkg::char_t c);
		logic [4:0] r;
		r = '0;
		if (c >= cmp_pkg::CH_0 && c <= cmp_pkg::CH_9)
			r = {1'b1, 4'(c - cmp_pkg::CH_0)};
		else if (c >= cmp_pkg::CH_UA && c <= cmp_pkg::CH_UF)
			r = {1'b1, 4'(c - cmp_pkg::CH_UA) + 4'd10};
		else if (c >= cmp_pkg::CH_LA && c <= cmp_pkg::CH_LF)
			r = {1'b1, 4'(c - cmp_pkg::CH_LA) + 4'd10};
		return r;
	endfunction

	// classify the head of the window with parallel compares
	always_comb begin
		logic [4:0] dec;
		full       = (fill_q == FILL_FULL);
		is_tm      = (win_q[0] == cfg.text_marker[cmp_pkg::CHAR_BITS-1:0]);
		is_bm      = (win_q[0] == cfg.back_marker[cmp_pkg::CHAR_BITS-1:0]);
		digits_ok  = 1'b1;
		head_value = '0;
		for (int i = 0; i < HEX_DIGITS; i++) begin
			dec = hex_decode(win_q[i+1]);
			digits_ok = digits_ok & dec[4];
			head_value[4*(HEX_DIGITS-1-i) +: 4] = dec[3:0];
		end
		is_color = (is_tm || is_bm) && full && (win_q[ESC_LEN-1] == win_q[0]) && digits_ok;
		if (is_color)
			head_kind = cmp_pkg::KIND_COLOR;
		else if (is_tm || is_bm)
			head_kind = cmp_pkg::KIND_TEXT;
		else if (win_q[0] == cmp_pkg::CH_NL)
			head_kind = cmp_pkg::KIND_NEWLINE;
		else if (win_q[0] == cmp_pkg::CH_TAB)
			head_kind = cmp_pkg::KIND_TAB;
		else
			head_kind = cmp_pkg::KIND_TEXT;
	end

	// sequencer: stream chars in, drain the window at the end of a string
	always_comb begin
		state_d  = state_q;
		proc     = !q_full && ((state_q == cmp_pkg::FE_RUN) ? full : (fill_q != '0));
		end_push = !q_full && (state_q == cmp_pkg::FE_DRAIN) && (fill_q == '0);
		s_tready = (state_q == cmp_pkg::FE_RUN) && (!full || proc);
		accept   = s_tvalid && s_tready;

		if (!proc)
			fill_after = fill_q;
		else if (is_color)
			fill_after = '0;
		else
			fill_after = fill_q - FILL_ONE;

		for (int i = 0; i < ESC_LEN; i++) begin
			if (accept && fill_after[IDX_W-1:0] == IDX_W'(i))
				win_d[i] = s_tdata[cmp_pkg::CHAR_BITS-1:0];
			else if (proc && i < ESC_LEN - 1)
				win_d[i] = win_q[(i < ESC_LEN - 1) ? i + 1 : i];
			else
				win_d[i] = win_q[i];
		end
		fill_d   = accept ? fill_after + FILL_ONE : fill_after;
		active_d = accept ? !s_tlast : active_q;

		unique case (state_q)
			cmp_pkg::FE_RUN: begin
				if (accept && s_tlast)
					state_d = cmp_pkg::FE_DRAIN;
			end
			cmp_pkg::FE_DRAIN: begin
				if (end_push)
					state_d = cmp_pkg::FE_RUN;
			end
			default: state_d = cmp_pkg::FE_RUN;
		endcase

		q_push         = proc || end_push;
		q_tok.kind     = end_push ? cmp_pkg::KIND_TEXT : head_kind;
		q_tok.space    = (win_q[0] == cmp_pkg::CH_SPACE);
		q_tok.text_sel = is_tm;
		q_tok.value    = head_value;
		q_tok.last     = end_push;
		idle           = !active_q && (state_q == cmp_pkg::FE_RUN);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			state_q  <= cmp_pkg::FE_RUN;
			active_q <= 1'b0;
		end else begin
			fill_q   <= fill_d;
			state_q  <= state_d;
			active_q <= active_d;
		end
	end

	// window storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < ESC_LEN; i++)
			win_q[i] <= win_d[i];
	end

	`CMP_ASSERT(a_color_needs_full, clk, arst_n, (q_push && !q_tok.last && q_tok.kind == cmp_pkg::KIND_COLOR) |-> (fill_q == FILL_FULL), "escape taken from a partial window")
	`CMP_ASSERT_NEXT(a_drain_shrinks, clk, arst_n, state_q == cmp_pkg::FE_DRAIN, fill_q <= $past(fill_q), "window grew while draining")

endmodule

>>> design/cmp_queue.sv
// short token queue between the front and back ends
// depends on cmp_pkg and color_markup_partitioner_macros.svh
`include "color_markup_partitioner_macros.svh"

module cmp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cmp_pkg::token_t push_tok,
	output logic            full,
	input  logic            pop,
	output cmp_pkg::token_t pop_tok,
	output logic            valid
);

	localparam int PTR_W = $clog2(cmp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(cmp_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cmp_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(cmp_pkg::QUEUE_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	cmp_pkg::token_t   slot_q [cmp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	// status and read side
	assign full    = (count_q == CNT_FULL);
	assign valid   = (count_q != '0);
	assign pop_tok = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (do_push && !do_pop)
				count_q <= count_q + CNT_ONE;
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_ONE;
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_tok;
	end

	`CMP_ASSERT(a_no_overflow, clk, arst_n, push |-> !full, "word pushed into a full queue")

endmodule

>>> design/cmp_back.sv
// back end: run accumulation, color state and the output register
// depends on cmp_pkg and color_markup_partitioner_macros.svh
`include "color_markup_partitioner_macros.svh"

module cmp_back #(
	parameter int HEX_DIGITS = cmp_pkg::HEX_DIGITS_DEF,
	parameter int MAX_LENGTH = cmp_pkg::MAX_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmp_pkg::cfg_back_t cfg,
	input  logic               q_valid,
	input  cmp_pkg::token_t    q_tok,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [119:0]       m_tdata,   // run_start, run_length, space_count,
	                                      // color_chars_before, text_color, back_color
	output logic [1:0]         m_tuser,   // run_kind
	output logic               m_tlast    // final_run
);

	localparam int ESC_LEN = HEX_DIGITS + 2;
	localparam int CNT_W   = $clog2(MAX_LENGTH + 1);
	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_LENGTH);
	localparam logic [CNT_W-1:0] MAX_START = CNT_W'(MAX_LENGTH - 1);
	localparam logic [CNT_W-1:0] ESC_ADD   = CNT_W'(ESC_LEN);
	localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

	logic              open_valid_q, open_valid_d;
	cmp_pkg::kind_t    open_kind_q, open_kind_d;
	logic [CNT_W-1:0]  open_start_q, open_start_d;
	logic [CNT_W-1:0]  open_len_q, open_len_d;
	logic [CNT_W-1:0]  open_spc_q, open_spc_d;
	logic [CNT_W-1:0]  open_base_q, open_base_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic [CNT_W-1:0]  ctot_q, ctot_d;
	logic [31:0]       cur_text_q, cur_text_d;
	logic [31:0]       cur_back_q, cur_back_d;

	logic              m_valid_q, m_valid_d;
	logic [119:0]      data_q;
	logic [1:0]        user_q;
	logic              last_q;

	logic              pop, is_color, skip, new_run, emit;
	logic [CNT_W-1:0]  len_base, spc_base;

	// add with saturation at the length limit
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, MAX_CNT}) ? MAX_CNT : s[CNT_W-1:0];
	endfunction

	// run bookkeeping for one word from the queue
	always_comb begin
		pop      = q_valid && (!m_valid_q || m_tready);
		is_color = (q_tok.kind == cmp_pkg::KIND_COLOR);
		skip     = cfg.strip && is_color;
		new_run  = (!open_valid_q || open_kind_q != q_tok.kind) && !skip;
		emit     = pop && open_valid_q && (q_tok.last || new_run);
		len_base = new_run ? '0 : open_len_q;
		spc_base = new_run ? '0 : open_spc_q;

		open_valid_d = open_valid_q;
		open_kind_d  = open_kind_q;
		open_start_d = open_start_q;
		open_len_d   = open_len_q;
		open_spc_d   = open_spc_q;
		open_base_d  = open_base_q;
		pos_d        = pos_q;
		ctot_d       = ctot_q;
		cur_text_d   = cur_text_q;
		cur_back_d   = cur_back_q;

		if (pop) begin
			if (q_tok.last) begin
				open_valid_d = 1'b0;
				open_kind_d  = cmp_pkg::KIND_TEXT;
				open_start_d = '0;
				open_len_d   = '0;
				open_spc_d   = '0;
				open_base_d  = '0;
				pos_d        = '0;
				ctot_d       = '0;
				cur_text_d   = cfg.def_text;
				cur_back_d   = cfg.def_back;
			end else begin
				if (new_run) begin
					open_valid_d = 1'b1;
					open_kind_d  = q_tok.kind;
					open_start_d = (pos_q < MAX_CNT) ? pos_q : MAX_START;
					open_base_d  = ctot_q;
				end
				open_spc_d = spc_base;
				if (is_color) begin
					open_len_d = len_base;
					if (!cfg.strip) begin
						if (q_tok.text_sel)
							cur_text_d = q_tok.value;
						else
							cur_back_d = q_tok.value;
						open_len_d = sat_add(len_base, ESC_ADD);
					end
					pos_d  = sat_add(pos_q, ESC_ADD);
					ctot_d = sat_add(ctot_q, ESC_ADD);
				end else begin
					if (q_tok.kind == cmp_pkg::KIND_TEXT && q_tok.space)
						open_spc_d = sat_add(spc_base, ONE);
					open_len_d = sat_add(len_base, ONE);
					pos_d      = sat_add(pos_q, ONE);
				end
			end
		end

		// default color writes, passed in by the top level only while the front end is idle
		if (cfg.load_text)
			cur_text_d = cfg.load_value;
		if (cfg.load_back)
			cur_back_d = cfg.load_value;

		if (emit)
			m_valid_d = 1'b1;
		else if (m_tready)
			m_valid_d = 1'b0;
		else
			m_valid_d = m_valid_q;
	end

	// control and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_valid_q <= 1'b0;
			open_kind_q  <= cmp_pkg::KIND_TEXT;
			open_start_q <= '0;
			open_len_q   <= '0;
			open_spc_q   <= '0;
			open_base_q  <= '0;
			pos_q        <= '0;
			ctot_q       <= '0;
			cur_text_q   <= cmp_pkg::DEFAULT_TEXT_RESET;
			cur_back_q   <= cmp_pkg::DEFAULT_BACK_RESET;
			m_valid_q    <= 1'b0;
		end else begin
			open_valid_q <= open_valid_d;
			open_kind_q  <= open_kind_d;
			open_start_q <= open_start_d;
			open_len_q   <= open_len_d;
			open_spc_q   <= open_spc_d;
			open_base_q  <= open_base_d;
			pos_q        <= pos_d;
			ctot_q       <= ctot_d;
			cur_text_q   <= cur_text_d;
			cur_back_q   <= cur_back_d;
			m_valid_q    <= m_valid_d;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= {5'b0, cur_back_q, cur_text_q, 13'(open_base_q), 13'(open_spc_q),
				13'(open_len_q), 12'(open_start_q)};
			user_q <= open_kind_q;
			last_q <= q_tok.last;
		end
	end

	assign q_pop    = pop;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	`CMP_ASSERT_NEXT(a_end_clears, clk, arst_n, pop && q_tok.last, !open_valid_q && pos_q == '0 && ctot_q == '0, "string state kept after end of string")
	`CMP_ASSERT(a_len_bound, clk, arst_n, open_len_q <= MAX_CNT && pos_q <= MAX_CNT, "run count past saturation limit")

endmodule

>>> design/color_markup_partitioner.sv
// a head char is classified and pushed once the window holds ESC_LEN chars and the queue is not full;
// the word of the run it closes passes the queue slot, the back end and the output register
// throughput: one char per cycle in steady state, set by the one-head-per-cycle window,
// while the queue is not full; after the last char of a string, input is held off until
// the window has drained and the end-of-string mark is in the queue
// reset: arst_n empties window and queue, clears run state and output valid; colors load their defaults
// top level of the color markup partitioner: configuration registers and wiring
// depends on cmp_pkg, cmp_front, cmp_queue and cmp_back

module color_markup_partitioner #(
	parameter int HEX_DIGITS = cmp_pkg::HEX_DIGITS_DEF,
	parameter int MAX_LENGTH = cmp_pkg::MAX_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,    // char_code
	input  logic                          s_tlast,    // last_char
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [119:0]                  m_tdata,    // run_start, run_length, space_count,
	                                                  // color_chars_before, text_color,
	                                                  // back_color, zero pad
	output logic [1:0]                    m_tuser,    // run_kind
	output logic                          m_tlast,    // final_run
	input  logic                          cfg_we,
	input  logic [cmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_wdata
);

	logic [15:0]         text_marker_q, back_marker_q;
	logic [31:0]         def_text_q, def_back_q;
	logic                strip_q;
	logic                idle;

	cmp_pkg::cfg_front_t cfg_front;
	cmp_pkg::cfg_back_t  cfg_back;

	logic                q_push, q_full, q_pop, q_valid;
	cmp_pkg::token_t     push_tok, pop_tok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_marker_q <= '0;
			back_marker_q <= '0;
			def_text_q    <= cmp_pkg::DEFAULT_TEXT_RESET;
			def_back_q    <= cmp_pkg::DEFAULT_BACK_RESET;
			strip_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmp_pkg::REG_TEXT_MARKER:  text_marker_q <= cfg_wdata[15:0];
				cmp_pkg::REG_BACK_MARKER:  back_marker_q <= cfg_wdata[15:0];
				cmp_pkg::REG_DEFAULT_TEXT: def_text_q    <= cfg_wdata;
				cmp_pkg::REG_DEFAULT_BACK: def_back_q    <= cfg_wdata;
				cmp_pkg::REG_STRIP:        strip_q       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// settings handed to each end
	always_comb begin
		cfg_front.text_marker = text_marker_q;
		cfg_front.back_marker = back_marker_q;
		cfg_back.strip        = strip_q;
		cfg_back.def_text     = def_text_q;
		cfg_back.def_back     = def_back_q;
		cfg_back.load_text    = cfg_we && (cfg_index == cmp_pkg::REG_DEFAULT_TEXT) && idle;
		cfg_back.load_back    = cfg_we && (cfg_index == cmp_pkg::REG_DEFAULT_BACK) && idle;
		cfg_back.load_value   = cfg_wdata;
	end

	cmp_front #(
		.HEX_DIGITS (HEX_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cfg      (cfg_front),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tok    (push_tok),
		.idle     (idle)
	);

	cmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (q_pop),
		.pop_tok  (pop_tok),
		.valid    (q_valid)
	);

	cmp_back #(
		.HEX_DIGITS (HEX_DIGITS),
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_back),
		.q_valid  (q_valid),
		.q_tok    (pop_tok),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> bench/tb_color_markup_partitioner.sv
`timescale 1ns / 100ps
// testbench of the color markup partitioner: a directed table, then random strings under
// several register settings; every run word is checked against an in-bench model
// depends on cmp_pkg and color_markup_partitioner

module tb_color_markup_partitioner;
	import cmp_pkg::*;

	localparam int ESC_LEN  = HEX_DIGITS_DEF + 2;
	localparam int MAX_LEN  = MAX_LENGTH_DEF;
	localparam int SETTLE   = 40;
	localparam int LIMIT    = 1500000;
	localparam int SHOW_MAX = 30;

	// one run word as it should leave the block
	typedef struct {
		kind_t       kind;
		logic [11:0] start;
		logic [12:0] len;
		logic [12:0] spaces;
		logic [12:0] prior;
		logic [31:0] tc;
		logic [31:0] bc;
		logic        fin;
	} run_t;

	typedef enum logic {
		OP_CHAR,
		OP_WRITE
	} op_t;

	// one row of the directed table: a char word or a register write
	typedef struct {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		bit          typed;
		run_t        want;
	} step_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;   // char_code
	logic                 s_tlast   = 1'b0; // last_char
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [119:0]         m_tdata;          // run_start, run_length, space_count,
	                                        // color_chars_before, text_color, back_color, pad
	logic [1:0]           m_tuser;          // run_kind
	logic                 m_tlast;          // final_run
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_wdata = '0;

	color_markup_partitioner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// partitioner model state
	logic [15:0] mark_text, mark_back;
	logic [31:0] dflt_text, dflt_back, color_text, color_back;
	bit          strip_on;
	logic [15:0] window [ESC_LEN];
	int          fill, position, color_total;
	bit          run_open;
	kind_t       run_kind;
	int          run_start, run_len, run_spaces, run_base;
	run_t        runs_due [$];

	// bench state
	step_t       script [$];
	logic [15:0] text_q [$];
	run_t        no_run;
	int          errors = 0;
	int          cycles = 0;
	int          ready_hold = 0;
	int          gap_odds = 8;
	bit          calm = 1'b0;

	always #5 clk = ~clk;

	function automatic int hex_value(logic [15:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		return -1;
	endfunction

	function automatic logic [15:0] hex_char(int v, bit lower);
		if (v < 10) return CH_0 + 16'(v);
		return (lower ? CH_LA : CH_UA) + 16'(v - 10);
	endfunction

	function automatic int clip(int v);
		return v > MAX_LEN ? MAX_LEN : v;
	endfunction

	// kind of the window head; a marker counts only when a whole escape follows
	function automatic kind_t head_kind();
		logic [15:0] c;
		c = window[0];
		if (c == mark_text || c == mark_back) begin
			if (fill < ESC_LEN || window[ESC_LEN-1] != c) return KIND_TEXT;
			for (int i = 1; i <= HEX_DIGITS_DEF; i++)
				if (hex_value(window[i]) < 0) return KIND_TEXT;
			return KIND_COLOR;
		end
		if (c == CH_NL) return KIND_NEWLINE;
		if (c == CH_TAB) return KIND_TAB;
		return KIND_TEXT;
	endfunction

	task automatic close_run(bit fin);
		run_t r;
		r.kind   = run_kind;
		r.start  = run_start[11:0];
		r.len    = run_len[12:0];
		r.spaces = run_spaces[12:0];
		r.prior  = run_base[12:0];
		r.tc     = color_text;
		r.bc     = color_back;
		r.fin    = fin;
		runs_due.insert(runs_due.size(), r);
	endtask

	task automatic clear_string();
		foreach (window[i]) window[i] = '0;
		fill        = 0;
		position    = 0;
		color_total = 0;
		run_open    = 1'b0;
		run_kind    = KIND_TEXT;
		run_start   = 0;
		run_len     = 0;
		run_spaces  = 0;
		run_base    = 0;
		color_text  = dflt_text;
		color_back  = dflt_back;
	endtask

	// classify the head char, close the open run on a change of kind, consume
	task automatic take_head();
		kind_t       k;
		logic [15:0] c;
		logic [31:0] v;
		int          n;
		k = head_kind();
		c = window[0];
		if ((!run_open || run_kind != k) && !(strip_on && k == KIND_COLOR)) begin
			if (run_open) close_run(1'b0);
			run_open   = 1'b1;
			run_kind   = k;
			run_start  = position < MAX_LEN ? position : MAX_LEN - 1;
			run_len    = 0;
			run_spaces = 0;
			run_base   = color_total;
		end
		if (k == KIND_COLOR) begin
			if (!strip_on) begin
				v = '0;
				for (int i = 1; i <= HEX_DIGITS_DEF; i++)
					v = (v << 4) | 32'(hex_value(window[i]));
				if (c == mark_text) color_text = v;
				else color_back = v;
				run_len = clip(run_len + ESC_LEN);
			end
			position    = clip(position + ESC_LEN);
			color_total = clip(color_total + ESC_LEN);
			n = ESC_LEN;
		end else begin
			if (k == KIND_TEXT && c == CH_SPACE) run_spaces = clip(run_spaces + 1);
			run_len  = clip(run_len + 1);
			position = clip(position + 1);
			n = 1;
		end
		// shift the consumed chars out of the window
		if (n >= fill) fill = 0;
		else begin
			for (int i = 0; i < fill - n; i++) window[i] = window[i + n];
			fill -= n;
		end
	endtask

	// model of one accepted char word; expected run words go to runs_due
	task automatic partition_char(logic [15:0] c, bit last);
		if (fill < ESC_LEN) begin
			window[fill] = c;
			fill++;
		end
		if (last) begin
			while (fill > 0) take_head();
			if (run_open) close_run(1'b1);
			clear_string();
		end else if (fill >= ESC_LEN) begin
			take_head();
		end
	endtask

	task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		bit idle;
		idle = fill == 0 && position == 0 && !run_open;
		case (idx)
			REG_TEXT_MARKER: mark_text = val[15:0];
			REG_BACK_MARKER: mark_back = val[15:0];
			REG_DEFAULT_TEXT: begin
				dflt_text = val;
				if (idle) color_text = val;
			end
			REG_DEFAULT_BACK: begin
				dflt_back = val;
				if (idle) color_back = val;
			end
			REG_STRIP: strip_on = val[0];
			default: ;
		endcase
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			errors++;
			if (errors <= SHOW_MAX)
				$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		end
	endtask

	// compare every accepted run word with the oldest expectation
	always @(posedge clk) begin
		run_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (runs_due.size() == 0) begin
				check_field("unexpected run word", 32'd1, 32'd0);
			end else begin
				r = runs_due.pop_front();
				check_field("run_kind", 32'(m_tuser), 32'(r.kind));
				check_field("run_start", 32'(m_tdata[11:0]), 32'(r.start));
				check_field("run_length", 32'(m_tdata[24:12]), 32'(r.len));
				check_field("space_count", 32'(m_tdata[37:25]), 32'(r.spaces));
				check_field("color_chars_before", 32'(m_tdata[50:38]), 32'(r.prior));
				check_field("text_color", m_tdata[82:51], r.tc);
				check_field("back_color", m_tdata[114:83], r.bc);
				check_field("pad", 32'(m_tdata[119:115]), 32'd0);
				check_field("final_run", 32'(m_tlast), 32'(r.fin));
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stalls: random low bursts between random ready stretches
	always @(negedge clk) begin
		if (calm) m_tready <= 1'b1;
		else if (ready_hold > 0) ready_hold--;
		else if (m_tready) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 17);
		end else begin
			m_tready <= 1'b1;
			ready_hold = $urandom_range(0, 59);
		end
	end

	// drive one char word from a falling edge until it is taken
	task automatic send_char(logic [15:0] ch, bit last, bit typed, run_t want);
		int n0;
		if (!calm && gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		n0 = runs_due.size();
		partition_char(ch, last);
		// typed rows replace the model's words with the hand-written one
		if (typed) begin
			while (runs_due.size() > n0) void'(runs_due.pop_back());
			runs_due.insert(runs_due.size(), want);
		end
		@(negedge clk);
	endtask

	task automatic send_string();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1, 1'b0, no_run);
	endtask

	// hold input until every expected word is out and the block has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		while (runs_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_write(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// escape of keep chars; flaw spoils one digit or the closing marker
	task automatic push_escape(logic [15:0] mk, int flaw, int keep);
		logic [15:0] e [ESC_LEN];
		logic [15:0] bad;
		e[0] = mk;
		for (int i = 1; i <= HEX_DIGITS_DEF; i++)
			e[i] = hex_char($urandom_range(0, 15), $urandom_range(0, 1));
		e[ESC_LEN-1] = mk;
		if (flaw > 0) begin
			bad = $urandom_range(0, 1) ? 16'($urandom_range(32, 126)) : 16'($urandom);
			if (flaw < ESC_LEN - 1 && hex_value(bad) >= 0) bad = CH_LF + 16'd1;
			if (flaw == ESC_LEN - 1 && bad == mk) bad = mk ^ 16'd1;
			e[flaw] = bad;
		end
		for (int i = 0; i < keep; i++) text_q.insert(text_q.size(), e[i]);
	endtask

	// random string of mostly well-formed pieces, some broken escapes and noise
	task automatic make_string(int pieces);
		logic [15:0] mk;
		text_q.delete();
		repeat (pieces) begin
			mk = $urandom_range(0, 1) ? mark_text : mark_back;
			case ($urandom_range(0, 11))
				0, 1, 2: push_escape(mk, -1, ESC_LEN);
				3: push_escape(mk, $urandom_range(1, ESC_LEN - 1), ESC_LEN);
				4: push_escape(mk, -1, $urandom_range(1, ESC_LEN - 1));
				5: repeat ($urandom_range(1, 5)) text_q.insert(text_q.size(), CH_SPACE);
				6: repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), CH_NL);
				7: repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), CH_TAB);
				8, 9: repeat ($urandom_range(1, 6))
					text_q.insert(text_q.size(), 16'($urandom_range(33, 126)));
				10: text_q.insert(text_q.size(), 16'($urandom));
				default: text_q.insert(text_q.size(), mk);
			endcase
		end
	endtask

	function automatic logic [15:0] pick_marker();
		case ($urandom_range(0, 10))
			5: return 16'h0000;
			6: return 16'hFFFF;
			7: return CH_NL;
			8: return CH_TAB;
			9: return CH_SPACE;
			10: return hex_char($urandom_range(0, 15), $urandom_range(0, 1));
			default: return 16'($urandom_range(33, 126));
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_char(logic [15:0] ch, bit last);
		step_t s;
		s.op    = OP_CHAR;
		s.a     = 32'(ch);
		s.b     = 32'(last);
		s.typed = 1'b0;
		script.insert(script.size(), s);
	endtask

	// single-char string under reset colors: one final run of length one at zero
	task automatic add_typed(logic [15:0] ch, kind_t kind, int spaces);
		step_t s;
		s.op          = OP_CHAR;
		s.a           = 32'(ch);
		s.b           = 32'd1;
		s.typed       = 1'b1;
		s.want.kind   = kind;
		s.want.start  = '0;
		s.want.len    = 13'd1;
		s.want.spaces = 13'(spaces);
		s.want.prior  = '0;
		s.want.tc     = DEFAULT_TEXT_RESET;
		s.want.bc     = DEFAULT_BACK_RESET;
		s.want.fin    = 1'b1;
		script.insert(script.size(), s);
	endtask

	task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		step_t s;
		s.op    = OP_WRITE;
		s.a     = 32'(idx);
		s.b     = val;
		s.typed = 1'b0;
		script.insert(script.size(), s);
	endtask

	initial begin
		string       digits;
		logic [15:0] tm, bm;
		logic [31:0] dt, db;
		bit          st;
		int          sent;

		mark_text = '0;
		mark_back = '0;
		dflt_text = DEFAULT_TEXT_RESET;
		dflt_back = DEFAULT_BACK_RESET;
		strip_on  = 1'b0;
		clear_string();

		// directed: field extremes and the single-char kinds under reset settings
		add_typed(16'hFFFF, KIND_TEXT, 0);
		add_typed(CH_SPACE, KIND_TEXT, 1);
		add_typed(CH_NL, KIND_NEWLINE, 0);
		add_typed(CH_TAB, KIND_TAB, 0);
		// both markers are zero at reset, so this escape sets the text color
		digits = "Ff09aA12";
		add_char(16'h0000, 1'b0);
		for (int i = 0; i < HEX_DIGITS_DEF; i++) add_char(16'(digits[i]), 1'b0);
		add_char(16'h0000, 1'b1);
		// newline as back marker without an escape behind it is text
		add_write(REG_TEXT_MARKER, 32'h23);
		add_write(REG_BACK_MARKER, 32'(CH_NL));
		add_typed(CH_NL, KIND_TEXT, 0);
		// escape cut short by the end of the string
		add_char(16'h23, 1'b0);
		add_char(CH_0 + 16'd1, 1'b0);
		add_char(CH_0 + 16'd2, 1'b1);
		// strip mode: a string of one escape yields no run
		add_write(REG_STRIP, 32'd1);
		digits = "7f3A90bc";
		add_char(16'h23, 1'b0);
		for (int i = 0; i < HEX_DIGITS_DEF; i++) add_char(16'(digits[i]), 1'b0);
		add_char(16'h23, 1'b1);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].op == OP_WRITE) begin
				settle();
				write_reg(script[i].a[CFG_IDX_W-1:0], script[i].b);
			end else begin
				send_char(script[i].a[15:0], script[i].b[0], script[i].typed, script[i].want);
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < 7; p++) begin
			settle();
			calm = (p == 6);
			tm = pick_marker();
			bm = $urandom_range(0, 3) == 0 ? tm : pick_marker();
			dt = pick_color();
			db = pick_color();
			st = $urandom_range(0, 1);
			if (p == 1) begin
				tm = 16'h0000;
				bm = 16'hFFFF;
				dt = 32'h0000_0000;
				db = 32'hFFFF_FFFF;
				st = 1'b0;
			end
			if (p == 2) st = 1'b1;
			if (p == 3) begin
				tm = 16'h23;
				bm = 16'h24;
				st = 1'b0;
			end
			write_reg(REG_TEXT_MARKER, {16'($urandom), tm});
			write_reg(REG_BACK_MARKER, {16'($urandom), bm});
			write_reg(REG_DEFAULT_TEXT, dt);
			write_reg(REG_DEFAULT_BACK, db);
			write_reg(REG_STRIP, {31'($urandom), st});
			sent = 0;
			while (sent < 50) begin
				case ($urandom_range(0, 3))
					0: gap_odds = 0;
					1: gap_odds = 3;
					2: gap_odds = 8;
					default: gap_odds = 20;
				endcase
				make_string($urandom_range(0, 7) == 0 ? $urandom_range(9, 20)
					: $urandom_range(1, 8));
				send_string();
				sent += text_q.size();
			end
		end

		settle();
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/cmp_pkg.sv
design/cmp_front.sv
design/cmp_queue.sv
design/cmp_back.sv
design/color_markup_partitioner.sv
bench/tb_color_markup_partitioner.sv
